@@ hw/rtl/lcpd_pkg.sv @@
package lcpd_pkg;

	// Operation codes carried in the mode field.
	localparam logic [1:0] MODE_LATCH  = 2'd0;
	localparam logic [1:0] MODE_STROBE = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	// Latch writes are taken only for the banks in this range.
	localparam logic [2:0] BANK_LOW  = 3'd1;
	localparam logic [2:0] BANK_HIGH = 3'd5;

	localparam int          LATCH_COUNT = 8;
	localparam logic [7:0]  LATCH_OFF   = 8'hFF;

	// One memory word holds the cells of eight consecutive rows of one column.
	localparam int          CELL_W         = 4;
	localparam int          CELLS_PER_WORD = 8;
	localparam int          WORD_W         = CELL_W * CELLS_PER_WORD;
	localparam logic [3:0]  INTENSITY_MAX  = 4'd7;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_STROBE = 4'b0100,
		ST_READ   = 4'b1000
	} state_t;

endpackage

@@ hw/rtl/led_column_persistence_display_core.sv @@
// A latch write is registered; a column strobe sweeps the ceil(ROWS/8) row groups of the column,
// one persistence-memory word written per cycle; a pixel read registers the addressed word,
// then delivers its cell once the output is free and returns to idle.
// The block takes a new request only while idle; the persistence memory has a single write port.
// Reset: arst_n clears control state and the latches to 0xFF at once, then a clearing
// pass writes zero to all ceil(ROWS/8) * COLUMNS memory words.
module led_column_persistence_display_core
	import lcpd_pkg::*;
#(
	parameter int COLUMNS = 256,
	parameter int ROWS    = 64,
	parameter int PERSIST = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [2:0] bank,
	input  logic [7:0] latch_data,
	input  logic [7:0] column,
	input  logic [5:0] row,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] intensity
);

	// The persistence store is organized as row groups of eight rows. Word address
	// is group * COLUMNS + column, and lane k of a word holds row 8 * group + k.
	// Each lane has its own write enable, so a strobe writes the lit rows of a group of eight
	// rows with a single word write, without reading the word first.
	localparam int GROUPS = (ROWS + CELLS_PER_WORD - 1) / CELLS_PER_WORD;
	localparam int DEPTH  = GROUPS * COLUMNS;
	localparam int AW     = $clog2(DEPTH);
	localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int LW     = $clog2(CELLS_PER_WORD);

	localparam logic [CELL_W-1:0] PERSIST_CELL = CELL_W'(PERSIST);

	state_t state_q;

	// Eight active-low LED latches, packed so they can be compared as a whole.
	logic [LATCH_COUNT-1:0][7:0] latch_q;

	logic [AW-1:0]     clr_addr_q;
	logic [AW-1:0]     strobe_addr_q;
	logic [GW-1:0]     grp_q;
	logic [AW-1:0]     rd_addr_q;
	logic [LW-1:0]     rd_lane_q;
	logic              rd_hit_q;
	logic [WORD_W-1:0] rd_word_q;
	logic              out_valid_q;
	logic [2:0]        intensity_q;

	logic [WORD_W-1:0] store_mem [DEPTH];

	logic              accept;
	logic              col_ok;
	logic              row_ok;
	logic [AW-1:0]     req_addr;
	logic              mem_re;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELLS_PER_WORD-1:0] mem_lane;
	logic [WORD_W-1:0] mem_wdata;
	logic [7:0]        strobe_latch;
	logic              out_free;
	logic [CELL_W-1:0] rd_cell;
	logic [CELL_W-1:0] cell_dec;
	logic [2:0]        read_value;
	logic              read_done;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign intensity = intensity_q;
	assign out_free  = !out_valid_q || out_ready;

	assign col_ok   = int'(column) < COLUMNS;
	assign row_ok   = int'(row) < ROWS;
	assign req_addr = AW'(row[5:3]) * AW'(COLUMNS) + AW'(column);

	// Pixel read: pick the addressed cell from the registered word and decay it.
	assign rd_cell    = rd_word_q[rd_lane_q * CELL_W +: CELL_W];
	assign cell_dec   = (rd_cell != '0) ? rd_cell - CELL_W'(1) : '0;
	assign read_value = rd_hit_q ? ((cell_dec > INTENSITY_MAX) ? 3'(INTENSITY_MAX)
		: cell_dec[2:0]) : 3'd0;
	assign read_done  = (state_q == ST_READ) && out_free;

	// Group g of rows is driven from latch 7 - g, row 8g + k from bit 7 - k.
	assign strobe_latch = latch_q[3'(LATCH_COUNT - 1) - 3'(grp_q)];

	assign mem_re = accept && (mode == MODE_READ) && col_ok && row_ok;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = strobe_addr_q;
		mem_lane  = '0;
		mem_wdata = {CELLS_PER_WORD{PERSIST_CELL}};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_lane  = '1;
				mem_wdata = '0;
			end
			ST_STROBE: begin
				mem_we = 1'b1;
				for (int k = 0; k < CELLS_PER_WORD; k++) begin
					mem_lane[k] = !strobe_latch[CELLS_PER_WORD - 1 - k];
				end
			end
			ST_READ: begin
				mem_we    = read_done && rd_hit_q && (rd_cell != '0);
				mem_waddr = rd_addr_q;
				mem_lane  = CELLS_PER_WORD'(1) << rd_lane_q;
				mem_wdata = {CELLS_PER_WORD{cell_dec}};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Persistence memory: one write port with lane enables, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int k = 0; k < CELLS_PER_WORD; k++) begin
				if (mem_lane[k]) begin
					store_mem[mem_waddr][k * CELL_W +: CELL_W] <=
						mem_wdata[k * CELL_W +: CELL_W];
				end
			end
		end
		if (mem_re) begin
			rd_word_q <= store_mem[req_addr];
		end
	end

	// Request fields kept for the strobe sweep and the read-modify-write.
	always_ff @(posedge clk) begin
		if (accept) begin
			strobe_addr_q <= AW'(column);
			rd_addr_q     <= req_addr;
			rd_lane_q     <= row[LW-1:0];
		end else if (state_q == ST_STROBE) begin
			strobe_addr_q <= strobe_addr_q + AW'(COLUMNS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			latch_q     <= {LATCH_COUNT{LATCH_OFF}};
			clr_addr_q  <= '0;
			grp_q       <= '0;
			rd_hit_q    <= 1'b0;
			out_valid_q <= 1'b0;
			intensity_q <= '0;
		end else begin
			// A word taken in the same cycle as a finishing read is replaced, not dropped.
			if (out_valid_q && out_ready && !read_done) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_LATCH: begin
								if (bank >= BANK_LOW && bank <= BANK_HIGH) begin
									latch_q[bank] <= latch_data;
								end
							end
							MODE_STROBE: begin
								grp_q <= '0;
								if (col_ok) begin
									state_q <= ST_STROBE;
								end else begin
									latch_q <= {LATCH_COUNT{LATCH_OFF}};
								end
							end
							MODE_READ: begin
								rd_hit_q <= col_ok && row_ok;
								state_q  <= ST_READ;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_STROBE: begin
					grp_q <= grp_q + GW'(1);
					if (grp_q == GW'(GROUPS - 1)) begin
						latch_q <= {LATCH_COUNT{LATCH_OFF}};
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					// Waits here while the previous word is still untaken.
					if (read_done) begin
						out_valid_q <= 1'b1;
						intensity_q <= read_value;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// A word appears only as the end of a pixel read.
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_READ))
		else $error("output word not produced by a pixel read");

	// Decay never yields more than the strobe level.
	a_intensity_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> int'(intensity_q) <= PERSIST)
		else $error("intensity above persistence level");

	// A finished strobe leaves every latch dark.
	a_strobe_clears_latches: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q == ST_STROBE) && state_q == ST_IDLE) |->
			latch_q == {LATCH_COUNT{LATCH_OFF}})
		else $error("latches not returned to off after strobe");

	// No word is accepted before the clearing pass has finished.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("input accepted during clearing pass");
`endif

endmodule
